/* rtl/atok_pkg.sv */
package atok_pkg;

  localparam int unsigned MaxTok = 5;
  localparam int unsigned CntW   = $clog2(MaxTok + 1);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChEquals = 8'h3D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChUnder  = 8'h5F;

  localparam logic [2:0] KindName    = 3'd0;
  localparam logic [2:0] KindValue   = 3'd1;
  localparam logic [2:0] KindCommit  = 3'd2;
  localparam logic [2:0] KindDiscard = 3'd3;
  localparam logic [2:0] KindEnd     = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } tok_t;

  // tokens produced by one input byte, entry 0 goes out first
  typedef struct packed {
    logic [CntW-1:0]        cnt;
    tok_t [MaxTok-1:0]      tok;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_name_start(input logic [7:0] c);
    return is_alpha(c) || (c == ChUnder);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_name_start(c) || is_digit(c);
  endfunction

endpackage

/* rtl/atok_front.sv */
module atok_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_char_i,
  input  logic              in_eos_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output atok_pkg::bundle_t q_data_o
);
  import atok_pkg::*;

  localparam logic [3:0] PhSeek      = 4'd0;
  localparam logic [3:0] PhName      = 4'd1;
  localparam logic [3:0] PhAfterName = 4'd2;
  localparam logic [3:0] PhAfterEq   = 4'd3;
  localparam logic [3:0] PhQuoted    = 4'd4;
  localparam logic [3:0] PhEscape    = 4'd5;
  localparam logic [3:0] PhNumeric   = 4'd6;
  localparam logic [3:0] PhIdent     = 4'd7;
  localparam logic [3:0] PhAfterVal  = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic       halted_q, halted_d;
  logic       accept;
  logic       ok;
  logic       do_after;
  logic       do_seek;
  bundle_t    bnd;
  logic [7:0] c;

  assign c          = in_char_i;
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (bnd.cnt != '0);
  assign q_data_o   = bnd;

  always_comb begin
    bnd      = '0;
    phase_d  = phase_q;
    halted_d = halted_q;
    ok       = 1'b1;
    do_after = 1'b0;
    do_seek  = 1'b0;

    if (!halted_q) begin
      unique case (phase_q)
        PhName: begin
          if (is_name_char(c)) begin
            bnd.tok[bnd.cnt] = '{kind: KindName, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
          end else if (is_ws(c)) begin
            phase_d = PhAfterName;
          end else if (c == ChEquals) begin
            phase_d = PhAfterEq;
          end else if (c == ChComma) begin
            bnd.tok[bnd.cnt] = '{kind: KindCommit, data: 8'd0};
            bnd.cnt = bnd.cnt + 1'b1;
            phase_d = PhSeek;
          end else begin
            ok = 1'b0;
          end
        end
        PhAfterName: begin
          if (is_ws(c)) begin
            phase_d = PhAfterName;
          end else if (c == ChEquals) begin
            phase_d = PhAfterEq;
          end else if (c == ChComma) begin
            bnd.tok[bnd.cnt] = '{kind: KindCommit, data: 8'd0};
            bnd.cnt = bnd.cnt + 1'b1;
            phase_d = PhSeek;
          end else begin
            ok = 1'b0;
          end
        end
        PhAfterEq: begin
          if (is_ws(c)) begin
            phase_d = PhAfterEq;
          end else if (c == ChQuote) begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
            phase_d = PhQuoted;
          end else if (is_digit(c)) begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
            phase_d = PhNumeric;
          end else if (is_name_start(c)) begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: ChQuote};
            bnd.cnt = bnd.cnt + 1'b1;
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
            phase_d = PhIdent;
          end else begin
            // empty identifier value
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: ChQuote};
            bnd.cnt = bnd.cnt + 1'b1;
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: ChQuote};
            bnd.cnt = bnd.cnt + 1'b1;
            do_after = 1'b1;
          end
        end
        PhQuoted: begin
          if (c == ChBslash) begin
            phase_d = PhEscape;
          end else begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
            if (c == ChQuote) begin
              phase_d = PhAfterVal;
            end
          end
        end
        PhEscape: begin
          if ((c == ChQuote) || (c == ChBslash)) begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: ChBslash};
            bnd.cnt = bnd.cnt + 1'b1;
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
            phase_d = PhQuoted;
          end else begin
            ok = 1'b0;
          end
        end
        PhNumeric: begin
          if (is_ws(c)) begin
            phase_d = PhAfterVal;
          end else begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
          end
        end
        PhIdent: begin
          if (is_name_char(c)) begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: c};
            bnd.cnt = bnd.cnt + 1'b1;
          end else begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: ChQuote};
            bnd.cnt = bnd.cnt + 1'b1;
            do_after = 1'b1;
          end
        end
        PhAfterVal: begin
          do_after = 1'b1;
        end
        default: begin
          do_seek = 1'b1;
        end
      endcase

      // between attributes, comma optional
      if (do_after) begin
        phase_d = PhAfterVal;
        if (!is_ws(c)) begin
          bnd.tok[bnd.cnt] = '{kind: KindCommit, data: 8'd0};
          bnd.cnt = bnd.cnt + 1'b1;
          if (c == ChComma) begin
            phase_d = PhSeek;
          end else begin
            do_seek = 1'b1;
          end
        end
      end

      if (do_seek) begin
        phase_d = PhSeek;
        if (is_name_start(c)) begin
          bnd.tok[bnd.cnt] = '{kind: KindName, data: c};
          bnd.cnt = bnd.cnt + 1'b1;
          phase_d = PhName;
        end else if (!is_ws(c)) begin
          ok = 1'b0;
        end
      end

      if (!ok) begin
        bnd.tok[bnd.cnt] = '{kind: KindDiscard, data: 8'd0};
        bnd.cnt = bnd.cnt + 1'b1;
        halted_d = 1'b1;
      end
    end

    if (in_eos_i) begin
      if (!halted_d) begin
        case (phase_d)
          PhEscape: begin
            bnd.tok[bnd.cnt] = '{kind: KindDiscard, data: 8'd0};
            bnd.cnt = bnd.cnt + 1'b1;
          end
          PhIdent: begin
            bnd.tok[bnd.cnt] = '{kind: KindValue, data: ChQuote};
            bnd.cnt = bnd.cnt + 1'b1;
            bnd.tok[bnd.cnt] = '{kind: KindCommit, data: 8'd0};
            bnd.cnt = bnd.cnt + 1'b1;
          end
          PhName, PhAfterName, PhAfterEq, PhQuoted, PhNumeric, PhAfterVal: begin
            bnd.tok[bnd.cnt] = '{kind: KindCommit, data: 8'd0};
            bnd.cnt = bnd.cnt + 1'b1;
          end
          default: begin
          end
        endcase
      end
      bnd.tok[bnd.cnt] = '{kind: KindEnd, data: 8'd0};
      bnd.cnt  = bnd.cnt + 1'b1;
      phase_d  = PhSeek;
      halted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSeek;
      halted_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      halted_q <= halted_d;
    end
  end

endmodule

/* rtl/atok_queue.sv */
module atok_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  atok_pkg::bundle_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output atok_pkg::bundle_t data_o
);
  import atok_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntQW = $clog2(Depth + 1);

  bundle_t              mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]     count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == CntQW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* rtl/atok_back.sv */
module atok_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  atok_pkg::bundle_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_kind_o,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o
);
  import atok_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            valid_q, valid_d;
  tok_t            tok_q, tok_d;
  logic            last_q, last_d;
  logic            load;
  logic            at_end;

  assign load    = (!valid_q || out_ready_i) && !q_empty_i;
  assign at_end  = (idx_q == q_data_i.cnt - 1'b1);
  assign q_pop_o = load && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    tok_d   = tok_q;
    last_d  = last_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      tok_d   = q_data_i.tok[idx_q];
      last_d  = at_end;
      idx_d   = at_end ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = tok_q.kind;
  assign out_byte_o  = tok_q.data;
  assign out_last_o  = last_q;

endmodule

/* rtl/attribute_list_tokenizer.sv */
// Attribute list tokenizer: takes one byte of a name=value list per request on the slave
// side (tlast marks the final byte of a string) and emits a token stream on the master side:
// name bytes, value bytes, attribute commits, a discard-and-stop marker and an end-of-string
// marker, with tlast on the final token caused by each input byte. A byte is taken every
// cycle while the token queue has room; the front end classifies it in that same cycle and
// queues its tokens (one to five) as one entry; a byte with none queues nothing. The back
// end sends one token per cycle while the sink is ready, from a registered output; the
// QUEUE_DEPTH-entry queue absorbs bursts of bytes giving many tokens, which pass the queue
// and then the output register. After an error, bytes give none until the end-marked byte.
module attribute_list_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // char_code
  input  logic       s_axis_tlast,   // end_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // token_byte
  output logic [2:0] m_axis_tuser,   // token_kind
  output logic       m_axis_tlast    // last_of_run
);
  import atok_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_wdata;
  bundle_t q_rdata;

  atok_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_eos_i   (s_axis_tlast),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  atok_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  atok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // marker tokens carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KindName) && (m_axis_tuser != KindValue)
      |-> (m_axis_tdata == 8'd0))
    else $error("marker token with nonzero byte");

  // end of string is always the final token of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindEnd) |-> m_axis_tlast)
    else $error("end token not last of run");

  // a full queue must stall the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !s_axis_tready)
    else $error("input taken while queue full");

endmodule

/* dv/token_checker.sv */
`timescale 1ns / 100ps

module token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  byte_data_i,
  input  logic        byte_last_i,
  input  logic        tok_valid_i,
  input  logic        tok_ready_i,
  input  logic [7:0]  tok_data_i,
  input  logic [2:0]  tok_kind_i,
  input  logic        tok_last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import atok_pkg::*;

  typedef enum logic [3:0] {
    PhSeek,
    PhName,
    PhAfterName,
    PhAfterEq,
    PhQuoted,
    PhEscape,
    PhNumeric,
    PhIdent,
    PhAfterVal
  } phase_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  phase_e phase;
  logic   halted;
  token_t burst[$];
  token_t expected_tokens[$];

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic leads_name(input logic [7:0] c);
    return (c inside {[8'd65:8'd90], [8'd97:8'd122]}) || (c == ChUnder);
  endfunction

  function automatic logic in_name(input logic [7:0] c);
    return leads_name(c) || (c inside {[8'd48:8'd57]});
  endfunction

  function automatic void put(input logic [2:0] kind, input logic [7:0] data);
    token_t t;
    t.kind = kind;
    t.data = data;
    t.last = 1'b0;
    burst = {burst, t};
  endfunction

  function automatic logic open_name(input logic [7:0] c);
    phase = PhSeek;
    if (is_blank(c)) return 1'b1;
    if (leads_name(c)) begin
      put(KindName, c);
      phase = PhName;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // missing comma only commits, the byte then starts the next name
  function automatic logic close_value(input logic [7:0] c);
    phase = PhAfterVal;
    if (is_blank(c)) return 1'b1;
    put(KindCommit, 8'h00);
    if (c == ChComma) begin
      phase = PhSeek;
      return 1'b1;
    end
    return open_name(c);
  endfunction

  function automatic logic advance(input logic [7:0] c);
    case (phase)
      PhName: begin
        if (in_name(c)) begin
          put(KindName, c);
          return 1'b1;
        end
        if (is_blank(c)) begin
          phase = PhAfterName;
          return 1'b1;
        end
        if (c == ChEquals) begin
          phase = PhAfterEq;
          return 1'b1;
        end
        if (c == ChComma) begin
          put(KindCommit, 8'h00);
          phase = PhSeek;
          return 1'b1;
        end
        return 1'b0;
      end
      PhAfterName: begin
        if (is_blank(c)) return 1'b1;
        if (c == ChEquals) begin
          phase = PhAfterEq;
          return 1'b1;
        end
        if (c == ChComma) begin
          put(KindCommit, 8'h00);
          phase = PhSeek;
          return 1'b1;
        end
        return 1'b0;
      end
      PhAfterEq: begin
        if (is_blank(c)) return 1'b1;
        if (c == ChQuote) begin
          put(KindValue, c);
          phase = PhQuoted;
          return 1'b1;
        end
        if (c inside {[8'd48:8'd57]}) begin
          put(KindValue, c);
          phase = PhNumeric;
          return 1'b1;
        end
        if (leads_name(c)) begin
          put(KindValue, ChQuote);
          put(KindValue, c);
          phase = PhIdent;
          return 1'b1;
        end
        // empty identifier value
        put(KindValue, ChQuote);
        put(KindValue, ChQuote);
        return close_value(c);
      end
      PhQuoted: begin
        if (c == ChBslash) begin
          phase = PhEscape;
          return 1'b1;
        end
        put(KindValue, c);
        if (c == ChQuote) phase = PhAfterVal;
        return 1'b1;
      end
      PhEscape: begin
        if ((c == ChQuote) || (c == ChBslash)) begin
          put(KindValue, ChBslash);
          put(KindValue, c);
          phase = PhQuoted;
          return 1'b1;
        end
        return 1'b0;
      end
      PhNumeric: begin
        if (is_blank(c)) begin
          phase = PhAfterVal;
          return 1'b1;
        end
        put(KindValue, c);
        return 1'b1;
      end
      PhIdent: begin
        if (in_name(c)) begin
          put(KindValue, c);
          return 1'b1;
        end
        put(KindValue, ChQuote);
        return close_value(c);
      end
      PhAfterVal: return close_value(c);
      default: return open_name(c);
    endcase
  endfunction

  function automatic void predict_tokens(input logic [7:0] c, input logic eos);
    burst.delete();
    if (!halted) begin
      if (!advance(c)) begin
        put(KindDiscard, 8'h00);
        halted = 1'b1;
      end
    end
    if (eos) begin
      if (!halted) begin
        case (phase)
          PhSeek: ;
          PhEscape: put(KindDiscard, 8'h00);
          PhIdent: begin
            put(KindValue, ChQuote);
            put(KindCommit, 8'h00);
          end
          default: put(KindCommit, 8'h00);
        endcase
      end
      put(KindEnd, 8'h00);
      phase  = PhSeek;
      halted = 1'b0;
    end
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expected_tokens = {expected_tokens, burst[i]};
  endfunction

  function automatic void check_token(input logic [2:0] kind, input logic [7:0] data,
                                      input logic last);
    token_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token kind %0d byte %h last %0b", $time, kind, data, last);
      fail_count_o = fail_count_o + 1;
      return;
    end
    want = expected_tokens.pop_front();
    if ((want.kind !== kind) || (want.data !== data) || (want.last !== last)) begin
      $display("%0t: expected kind %0d byte %h last %0b, got kind %0d byte %h last %0b",
               $time, want.kind, want.data, want.last, kind, data, last);
      fail_count_o = fail_count_o + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase        = PhSeek;
      halted       = 1'b0;
      fail_count_o = 0;
      expected_tokens.delete();
    end else begin
      if (tok_valid_i && tok_ready_i) check_token(tok_kind_i, tok_data_i, tok_last_i);
      if (byte_valid_i && byte_ready_i) predict_tokens(byte_data_i, byte_last_i);
    end
    pending_o = expected_tokens.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import atok_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongStall   = 60;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseBytes  = 30;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int unsigned fail_count;
  int unsigned tokens_pending;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 34;
  int unsigned take_idle_pct = 86;
  logic        hold_off_req  = 1'b0;

  attribute_list_tokenizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  token_checker tokens_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_i (s_axis_tready),
    .byte_data_i  (s_axis_tdata),
    .byte_last_i  (s_axis_tlast),
    .tok_valid_i  (m_axis_tvalid),
    .tok_ready_i  (m_axis_tready),
    .tok_data_i   (m_axis_tdata),
    .tok_kind_i   (m_axis_tuser),
    .tok_last_i   (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (tokens_pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // token sink, with one long hold-off on request
  initial begin
    int unsigned stall_left;
    logic        hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_req && !hold_done) begin
        hold_done     = 1'b1;
        stall_left    = LongStall;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] blank_char();
    int unsigned r;
    r = $urandom_range(5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] name_lead_char();
    int unsigned r;
    r = $urandom_range(52);
    if (r == 52) return ChUnder;
    return (r < 26) ? 8'(65 + r) : 8'(97 + r - 26);
  endfunction

  function automatic logic [7:0] name_body_char();
    if ($urandom_range(4) == 0) return 8'(48 + $urandom_range(9));
    return name_lead_char();
  endfunction

  // one mostly well-formed attribute list with random content
  task automatic send_random_list(output int unsigned n);
    logic [7:0]  text_q[$];
    int unsigned form;
    int unsigned r;
    logic [7:0]  c;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 4)) text_q = {text_q, 8'($urandom_range(255))};
    end else begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(3) == 0) text_q = {text_q, blank_char()};
        text_q = {text_q, name_lead_char()};
        repeat ($urandom_range(3)) text_q = {text_q, name_body_char()};
        if ($urandom_range(4) == 0) text_q = {text_q, blank_char()};
        form = $urandom_range(4);
        if (form != 0) begin
          text_q = {text_q, ChEquals};
          if ($urandom_range(4) == 0) text_q = {text_q, blank_char()};
          case (form)
            1: begin
              text_q = {text_q, ChQuote};
              repeat ($urandom_range(4)) begin
                r = $urandom_range(11);
                if (r == 0) begin
                  text_q = {text_q, ChBslash};
                  text_q = {text_q, ChQuote};
                end else if (r == 1) begin
                  text_q = {text_q, ChBslash};
                  text_q = {text_q, ChBslash};
                end else if (r == 2) begin
                  text_q = {text_q, ChBslash};
                  text_q = {text_q, 8'($urandom_range(255))};
                end else begin
                  c = 8'($urandom_range(255));
                  if ((c == ChQuote) || (c == ChBslash)) c = 8'd97;
                  text_q = {text_q, c};
                end
              end
              if ($urandom_range(5) != 0) text_q = {text_q, ChQuote};
            end
            2: begin
              text_q = {text_q, 8'(48 + $urandom_range(9))};
              repeat ($urandom_range(3)) begin
                r = $urandom_range(4);
                case (r)
                  0: text_q = {text_q, 8'(48 + $urandom_range(9))};
                  1: text_q = {text_q, ChComma};
                  2: text_q = {text_q, 8'd46};
                  3: text_q = {text_q, 8'($urandom_range(255))};
                  default: text_q = {text_q, 8'd120};
                endcase
              end
            end
            3: begin
              text_q = {text_q, name_lead_char()};
              repeat ($urandom_range(3)) text_q = {text_q, name_body_char()};
            end
            default: begin
              if ($urandom_range(1) == 0) text_q = {text_q, ChComma};
              else text_q = {text_q, 8'($urandom_range(128, 255))};
            end
          endcase
        end
        r = $urandom_range(3);
        if (r == 0) text_q = {text_q, ChComma};
        else if (r == 1) text_q = {text_q, blank_char()};
        else if (r == 2) begin
          text_q = {text_q, ChComma};
          text_q = {text_q, 8'd32};
        end
      end
      if ($urandom_range(7) == 0) begin
        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
      end
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    n = text_q.size();
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned take_pct);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    send_idle_pct = send_pct;
    take_idle_pct <= take_pct;
    while (sent < PhaseBytes) begin
      send_random_list(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(" ");
    send_text("n,v=");
    send_text("a=b c=1,2");
    send_text("j=\"\\\"\\\\\\");
    send_text("q=\"\\a");
    send_text("e==");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);

    run_random_phase(34, 86);
    run_random_phase(86, 34);
    hold_off_req <= 1'b1;
    run_random_phase(0, 0);
    s_axis_tvalid <= 1'b0;

    do @(negedge clk_i); while (tokens_pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/atok_pkg.sv
rtl/atok_front.sv
rtl/atok_queue.sv
rtl/atok_back.sv
rtl/attribute_list_tokenizer.sv
dv/token_checker.sv
dv/testbench.sv
